// ===== rtl/mvtv_pkg.sv =====
// Shared types, constants and the magic lookup for the move table image validator.
package mvtv_pkg;

	localparam int unsigned OFF_W      = 32;
	localparam int unsigned END_W      = 34;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam int unsigned DEF_MAX_POSITIONS = 10000000;
	localparam int unsigned DEF_MAX_MOVES     = 50000000;

	localparam logic [OFF_W-1:0] HDR_LEN    = OFF_W'(24);
	localparam logic [OFF_W-1:0] HDR_LAST   = OFF_W'(23);
	localparam logic [OFF_W-1:0] FIRST_KEY  = OFF_W'(31);
	localparam logic [OFF_W-1:0] OFF_SAT    = '1;

	// header byte offsets at which a field completes; HOFF_MAGIC is the magic length
	localparam logic [4:0] HOFF_VERSION = 5'd11;
	localparam logic [4:0] HOFF_POS     = 5'd15;
	localparam logic [4:0] HOFF_MOV     = 5'd19;
	localparam logic [4:0] HOFF_PLY     = 5'd21;
	localparam logic [4:0] HOFF_MIN     = 5'd23;
	localparam logic [4:0] HOFF_MAGIC   = 5'd8;

	// position entry byte codes (offset inside the 16-byte entry)
	localparam logic [3:0] PREL_KEY   = 4'd7;
	localparam logic [3:0] PREL_OFS   = 4'd11;
	localparam logic [3:0] PREL_CNT   = 4'd13;
	localparam logic [3:0] PREL_RSV   = 4'd14;

	// move entry byte codes
	localparam logic [2:0] MREL_MOVE_HI = 3'd1;
	localparam logic [2:0] MREL_RSV_LO  = 3'd2;
	localparam logic [2:0] MREL_RSV_HI  = 3'd3;
	localparam logic [2:0] MREL_WEIGHT  = 3'd7;

	localparam logic [2:0] PROMO_MAX = 3'd4;

	typedef enum logic [1:0] {
		KIND_HDR,
		KIND_BODY,
		KIND_SAT
	} kind_t;

	typedef struct packed {
		logic [7:0]       byte_value;
		logic             last_byte;
		kind_t            kind;
		logic [OFF_W-1:0] off;
	} req_t;

	function automatic logic [7:0] magic_byte(input logic [2:0] idx);
		logic [7:0] b;
		case (idx)
			3'd0: b = 8'h48;
			3'd1: b = 8'h45;
			3'd2: b = 8'h42;
			3'd3: b = 8'h49;
			3'd4: b = 8'h42;
			3'd5: b = 8'h4F;
			3'd6: b = 8'h4F;
			3'd7: b = 8'h4B;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// ===== rtl/mvtv_front.sv =====
// Front end: byte offset counter and header/body/saturation tagging.
module mvtv_front import mvtv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] byte_value,
	input  logic       last_byte,
	input  logic       q_full,
	output logic       q_push,
	output req_t       q_req
);

	logic [OFF_W-1:0] off_q;

	assign in_stall = q_full;
	assign q_push   = in_valid & ~q_full;

	always_comb begin
		q_req.byte_value = byte_value;
		q_req.last_byte  = last_byte;
		q_req.off        = off_q;
		if (off_q == OFF_SAT) begin
			q_req.kind = KIND_SAT;
		end else if (off_q < HDR_LEN) begin
			q_req.kind = KIND_HDR;
		end else begin
			q_req.kind = KIND_BODY;
		end
	end

	// saturating counter, back to zero after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= '0;
		end else if (q_push) begin
			if (last_byte) begin
				off_q <= '0;
			end else if (off_q != OFF_SAT) begin
				off_q <= off_q + OFF_W'(1);
			end
		end
	end

endmodule

// ===== rtl/mvtv_queue.sv =====
// Small request queue between front and back end.
module mvtv_queue import mvtv_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  req_t push_req,
	input  logic pop,
	output req_t head,
	output logic empty,
	output logic full
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	req_t          mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == CW'(DEPTH));
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// ===== rtl/mvtv_back.sv =====
// Back end: field assembly, header/entry checks and the result register.
module mvtv_back import mvtv_pkg::*; #(
	parameter int unsigned MAX_POSITIONS = DEF_MAX_POSITIONS,
	parameter int unsigned MAX_MOVES     = DEF_MAX_MOVES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] format_version,
	input  req_t        head,
	input  logic        q_empty,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        image_ok,
	output logic [23:0] position_total,
	output logic [25:0] move_total,
	output logic [15:0] max_ply,
	output logic [15:0] min_moves
);

	logic [63:0]      shift_q;
	logic [31:0]      version_q;
	logic [31:0]      pcnt_q;
	logic [31:0]      mcnt_q;
	logic [15:0]      ply_q;
	logic [15:0]      min_q;
	logic [63:0]      prev_key_q;
	logic [31:0]      eofs_q;
	logic             failed_q;
	logic [END_W-1:0] pos_end_q;
	logic [END_W-1:0] mov_end_q;

	logic             out_valid_q;
	logic             ok_q;
	logic [23:0]      ptot_q;
	logic [25:0]      mtot_q;
	logic [15:0]      ply_out_q;
	logic [15:0]      min_out_q;

	logic [63:0]      ns;
	logic [7:0]       b;
	logic [OFF_W-1:0] off;
	logic [4:0]       hoff;
	logic [3:0]       prel;
	logic [2:0]       mrel;
	logic [END_W-1:0] off_w;
	logic             in_pos;
	logic             in_mov;
	logic             fail_now;
	logic             failed_nx;
	logic             fin;
	logic             ok;

	assign q_pop = ~q_empty & (~head.last_byte | ~out_valid_q | ~out_stall);

	always_comb begin
		b        = head.byte_value;
		off      = head.off;
		ns       = {b, shift_q[63:8]};
		hoff     = off[4:0];
		prel     = off[3:0] ^ 4'd8;
		mrel     = off[2:0];
		off_w    = END_W'(off);
		in_pos   = off_w < pos_end_q;
		in_mov   = off_w < mov_end_q;
		fail_now = 1'b0;
		case (head.kind)
			KIND_SAT: fail_now = 1'b1;
			KIND_HDR: begin
				if (hoff < HOFF_MAGIC) begin
					fail_now = (b != magic_byte(hoff[2:0]));
				end else if (hoff == HOFF_MIN) begin
					fail_now = (version_q != format_version) ||
						(pcnt_q > 32'(MAX_POSITIONS)) || (mcnt_q > 32'(MAX_MOVES));
				end
			end
			KIND_BODY: begin
				if (in_pos) begin
					if (prel == PREL_KEY) begin
						fail_now = (off != FIRST_KEY) && (ns <= prev_key_q);
					end else if (prel == PREL_CNT) begin
						fail_now = ({1'b0, eofs_q} + 33'(ns[63:48])) > {1'b0, mcnt_q};
					end else if (prel >= PREL_RSV) begin
						fail_now = (b != 8'd0);
					end
				end else if (in_mov) begin
					if (mrel == MREL_MOVE_HI) begin
						fail_now = b[7] || (b[6:4] > PROMO_MAX);
					end else if (mrel == MREL_RSV_LO || mrel == MREL_RSV_HI) begin
						fail_now = (b != 8'd0);
					end else if (mrel == MREL_WEIGHT) begin
						fail_now = (ns[63:32] == 32'd0);
					end
				end else begin
					fail_now = 1'b1;
				end
			end
			default: fail_now = 1'b1;
		endcase
		failed_nx = failed_q | fail_now;
		if (off == HDR_LAST) begin
			fin = (pcnt_q == 32'd0) && (mcnt_q == 32'd0);
		end else begin
			fin = (off_w + END_W'(1)) == mov_end_q;
		end
		ok = ~failed_nx && (off >= HDR_LAST) && fin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q    <= '0;
			version_q  <= '0;
			pcnt_q     <= '0;
			mcnt_q     <= '0;
			ply_q      <= '0;
			min_q      <= '0;
			prev_key_q <= '0;
			eofs_q     <= '0;
			failed_q   <= 1'b0;
			pos_end_q  <= '0;
			mov_end_q  <= '0;
		end else if (q_pop) begin
			if (head.last_byte) begin
				shift_q    <= '0;
				version_q  <= '0;
				pcnt_q     <= '0;
				mcnt_q     <= '0;
				ply_q      <= '0;
				min_q      <= '0;
				prev_key_q <= '0;
				eofs_q     <= '0;
				failed_q   <= 1'b0;
				pos_end_q  <= '0;
				mov_end_q  <= '0;
			end else begin
				shift_q  <= ns;
				failed_q <= failed_nx;
				if (head.kind == KIND_HDR) begin
					case (hoff)
						HOFF_VERSION: version_q <= ns[63:32];
						HOFF_POS:     pcnt_q    <= ns[63:32];
						HOFF_MOV: begin
							mcnt_q    <= ns[63:32];
							pos_end_q <= END_W'(HDR_LEN) + END_W'({pcnt_q, 4'd0});
						end
						HOFF_PLY:     ply_q     <= ns[63:48];
						HOFF_MIN: begin
							min_q     <= ns[63:48];
							mov_end_q <= pos_end_q + END_W'({mcnt_q, 3'd0});
						end
						default: ;
					endcase
				end else if (head.kind == KIND_BODY && in_pos) begin
					if (prel == PREL_KEY) begin
						prev_key_q <= ns;
					end else if (prel == PREL_OFS) begin
						eofs_q <= ns[63:32];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop && head.last_byte) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && head.last_byte) begin
			ok_q      <= ok;
			ptot_q    <= ok ? pcnt_q[23:0] : '0;
			mtot_q    <= ok ? mcnt_q[25:0] : '0;
			ply_out_q <= ok ? ply_q : '0;
			min_out_q <= ok ? (hoff == HOFF_MIN && head.kind == KIND_HDR ? ns[63:48] : min_q)
				: '0;
		end
	end

	assign out_valid      = out_valid_q;
	assign image_ok       = ok_q;
	assign position_total = ptot_q;
	assign move_total     = mtot_q;
	assign max_ply        = ply_out_q;
	assign min_moves      = min_out_q;

endmodule

// ===== rtl/move_table_image_validator.sv =====
// Top level of the move table image validator.
//
// Streams a move table image in one byte per request (little-endian fields) and
// checks the 24-byte header, every 16-byte position entry and every 8-byte move
// entry, plus the total length implied by the header counts. One result comes
// out for each request flagged last_byte: image_ok and the header values
// (position_total, move_total, max_ply, min_moves), all zero on failure; the
// checker then starts over on a fresh image. It takes one byte per clock while
// in_stall is low: each byte needs only a field shift and a handful of compares.
// The front end counts bytes and tags each request as header, body or
// counter-saturated; a two-deep request queue separates it from the back end,
// which assembles fields and runs the checks. A result sits in an output
// register until the sink drops out_stall; only the last request of the
// following image waits on it, the bytes before it keep flowing. in_stall rises
// only when the queue holds two requests. format_version (reset value 1) is set
// via cfg_we/cfg_wdata, by the user only with no image in flight (unenforced).
module move_table_image_validator import mvtv_pkg::*; #(
	parameter int unsigned MAX_POSITIONS = DEF_MAX_POSITIONS,
	parameter int unsigned MAX_MOVES     = DEF_MAX_MOVES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  byte_value,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        image_ok,
	output logic [23:0] position_total,
	output logic [25:0] move_total,
	output logic [15:0] max_ply,
	output logic [15:0] min_moves
);

	logic [31:0] format_version_q;
	logic        q_push;
	logic        q_pop;
	logic        q_full;
	logic        q_empty;
	req_t        q_req;
	req_t        q_head;

	// expected header version
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_version_q <= 32'd1;
		end else if (cfg_we) begin
			format_version_q <= cfg_wdata;
		end
	end

	mvtv_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.byte_value (byte_value),
		.last_byte  (last_byte),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_req      (q_req)
	);

	mvtv_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_req (q_req),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty),
		.full     (q_full)
	);

	mvtv_back #(
		.MAX_POSITIONS (MAX_POSITIONS),
		.MAX_MOVES     (MAX_MOVES)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.format_version (format_version_q),
		.head           (q_head),
		.q_empty        (q_empty),
		.q_pop          (q_pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.image_ok       (image_ok),
		.position_total (position_total),
		.move_total     (move_total),
		.max_ply        (max_ply),
		.min_moves      (min_moves)
	);

endmodule

// ===== rtl/mvtv_checker.sv =====
// Port-level checks for the move table image validator, bound to the top level.
module mvtv_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        last_byte,
	input logic        out_valid,
	input logic        out_stall,
	input logic        image_ok,
	input logic [23:0] position_total,
	input logic [25:0] move_total,
	input logic [15:0] max_ply,
	input logic [15:0] min_moves
);

	logic [3:0] pend_q;
	logic       in_last;
	logic       out_take;

	assign in_last  = in_valid & ~in_stall & last_byte;
	assign out_take = out_valid & ~out_stall;

	// last-byte requests taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_last && !out_take) begin
			pend_q <= pend_q + 4'd1;
		end else if (out_take && !in_last) begin
			pend_q <= pend_q - 4'd1;
		end
	end

	a_result_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 4'd0)
		else $error("result without a pending last byte");

	a_fail_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !image_ok |-> position_total == 24'd0 && move_total == 26'd0 &&
			max_ply == 16'd0 && min_moves == 16'd0)
		else $error("failed image reports nonzero header values");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(image_ok) &&
			$stable(position_total) && $stable(move_total))
		else $error("stalled result changed");

endmodule

bind move_table_image_validator mvtv_checker u_mvtv_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.last_byte      (last_byte),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.image_ok       (image_ok),
	.position_total (position_total),
	.move_total     (move_total),
	.max_ply        (max_ply),
	.min_moves      (min_moves)
);
